FILE: src/fud_pkg.sv
`timescale 1ns / 1ps

package fud_pkg;

  // Result kinds as seen on out_kind.
  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2,
    KIND_BODY_END = 2'd3
  } kind_t;

  // Pair status as seen on out_pair_status.
  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_NO_EQUALS   = 2'd1,
    ST_EMPTY_KEY   = 2'd2,
    ST_OVER_BUDGET = 2'd3
  } stat_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    stat_t      status;
    logic       ok;
    logic       fin;
  } res_t;

  // Up to four results caused by one input beat, in delivery order.
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [2:0]         cnt;
  } grp_t;

  function automatic logic hex_ok(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nib(logic [7:0] c);
    logic [7:0] t;
    if ((c >= 8'h61) && (c <= 8'h66)) begin
      t = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      t = c - 8'h37;
    end else begin
      t = c - 8'h30;
    end
    return t[3:0];
  endfunction

  function automatic res_t mk_res(logic [7:0] data, kind_t kind, stat_t status, logic ok);
    res_t r;
    r.data   = data;
    r.kind   = kind;
    r.status = status;
    r.ok     = ok;
    r.fin    = 1'b0;
    return r;
  endfunction

  function automatic grp_t grp_push(grp_t g, res_t r);
    grp_t o;
    o = g;
    if (g.cnt < 3'd4) begin
      o.ent[g.cnt[1:0]] = r;
      o.cnt = g.cnt + 3'd1;
    end
    return o;
  endfunction

endpackage

FILE: src/fud_step.sv
`timescale 1ns / 1ps

module fud_step #(
  parameter int CNT_W = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic [15:0]     pair_limit,
  output fud_pkg::grp_t   grp
);

  localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

  logic [1:0]       hc_r, hc_nxt;
  logic [7:0]       hch_r, hch_nxt;
  logic             inv_r, inv_nxt;
  logic             kne_r, kne_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic             bx_r, bx_nxt;

  logic [CMP_W-1:0] acc_ext;
  logic [CMP_W-1:0] lim_ext;
  logic             over_limit;

  fud_pkg::grp_t    g;
  fud_pkg::stat_t   st;
  fud_pkg::kind_t   dkind;
  logic             done;
  logic [1:0]       last_idx;

  assign acc_ext    = CMP_W'(acc_r);
  assign lim_ext    = CMP_W'(pair_limit);
  assign over_limit = (pair_limit != 16'd0) && (acc_ext >= lim_ext);

  always_comb begin
    hc_nxt   = hc_r;
    hch_nxt  = hch_r;
    inv_nxt  = inv_r;
    kne_nxt  = kne_r;
    acc_nxt  = acc_r;
    bx_nxt   = bx_r;
    g        = '0;
    st       = fud_pkg::ST_ACCEPTED;
    done     = 1'b0;
    dkind    = inv_r ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
    last_idx = 2'd0;

    if (!bx_r) begin
      if (byte_i == fud_pkg::CH_AMP) begin
        if (hc_nxt != 2'd0) begin
          g = fud_pkg::grp_push(g, fud_pkg::mk_res(fud_pkg::CH_PCT, dkind,
                                                   fud_pkg::ST_ACCEPTED, 1'b0));
        end
        if (hc_nxt == 2'd2) begin
          g = fud_pkg::grp_push(g, fud_pkg::mk_res(hch_nxt, dkind,
                                                   fud_pkg::ST_ACCEPTED, 1'b0));
        end
        hc_nxt = 2'd0;
        if (!inv_r) begin
          st = fud_pkg::ST_NO_EQUALS;
        end else if (!kne_r) begin
          st = fud_pkg::ST_EMPTY_KEY;
        end else begin
          st = fud_pkg::ST_ACCEPTED;
        end
        g = fud_pkg::grp_push(g, fud_pkg::mk_res(8'd0, fud_pkg::KIND_PAIR_END, st, 1'b0));
        if ((st == fud_pkg::ST_ACCEPTED) && (acc_r != {CNT_W{1'b1}})) begin
          acc_nxt = acc_r + CNT_W'(1);
        end
        inv_nxt = 1'b0;
        kne_nxt = 1'b0;
      end else if ((byte_i == fud_pkg::CH_EQ) && !inv_r) begin
        if (hc_nxt != 2'd0) begin
          g = fud_pkg::grp_push(g, fud_pkg::mk_res(fud_pkg::CH_PCT, dkind,
                                                   fud_pkg::ST_ACCEPTED, 1'b0));
        end
        if (hc_nxt == 2'd2) begin
          g = fud_pkg::grp_push(g, fud_pkg::mk_res(hch_nxt, dkind,
                                                   fud_pkg::ST_ACCEPTED, 1'b0));
        end
        hc_nxt = 2'd0;
        if (over_limit) begin
          bx_nxt = 1'b1;
          if (!last_i) begin
            g = fud_pkg::grp_push(g, fud_pkg::mk_res(8'd0, fud_pkg::KIND_PAIR_END,
                                                     fud_pkg::ST_OVER_BUDGET, 1'b0));
          end
        end else begin
          inv_nxt = 1'b1;
        end
      end else begin
        if (!inv_r) begin
          kne_nxt = 1'b1;
        end
        // A broken escape emits its literal bytes and then looks at the
        // current byte once more, so at most two passes are needed.
        for (int p = 0; p < 2; p++) begin
          if (!done) begin
            if (hc_nxt == 2'd0) begin
              if (byte_i == fud_pkg::CH_PCT) begin
                hc_nxt = 2'd1;
              end else if (byte_i == fud_pkg::CH_PLUS) begin
                g = fud_pkg::grp_push(g, fud_pkg::mk_res(fud_pkg::CH_SPACE, dkind,
                                                         fud_pkg::ST_ACCEPTED, 1'b0));
              end else begin
                g = fud_pkg::grp_push(g, fud_pkg::mk_res(byte_i, dkind,
                                                         fud_pkg::ST_ACCEPTED, 1'b0));
              end
              done = 1'b1;
            end else if (hc_nxt == 2'd1) begin
              if (fud_pkg::hex_ok(byte_i)) begin
                hch_nxt = byte_i;
                hc_nxt  = 2'd2;
                done    = 1'b1;
              end else begin
                g = fud_pkg::grp_push(g, fud_pkg::mk_res(fud_pkg::CH_PCT, dkind,
                                                         fud_pkg::ST_ACCEPTED, 1'b0));
                hc_nxt = 2'd0;
              end
            end else begin
              if (fud_pkg::hex_ok(byte_i)) begin
                g = fud_pkg::grp_push(g, fud_pkg::mk_res(
                      {fud_pkg::hex_nib(hch_nxt), fud_pkg::hex_nib(byte_i)}, dkind,
                      fud_pkg::ST_ACCEPTED, 1'b0));
                hc_nxt = 2'd0;
                done   = 1'b1;
              end else begin
                g = fud_pkg::grp_push(g, fud_pkg::mk_res(fud_pkg::CH_PCT, dkind,
                                                         fud_pkg::ST_ACCEPTED, 1'b0));
                g = fud_pkg::grp_push(g, fud_pkg::mk_res(hch_nxt, dkind,
                                                         fud_pkg::ST_ACCEPTED, 1'b0));
                hc_nxt = 2'd0;
              end
            end
          end
        end
      end
    end

    if (last_i) begin
      dkind = inv_nxt ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
      if (!bx_nxt) begin
        if (hc_nxt != 2'd0) begin
          g = fud_pkg::grp_push(g, fud_pkg::mk_res(fud_pkg::CH_PCT, dkind,
                                                   fud_pkg::ST_ACCEPTED, 1'b0));
        end
        if (hc_nxt == 2'd2) begin
          g = fud_pkg::grp_push(g, fud_pkg::mk_res(hch_nxt, dkind,
                                                   fud_pkg::ST_ACCEPTED, 1'b0));
        end
      end
      if (bx_nxt) begin
        st = fud_pkg::ST_OVER_BUDGET;
      end else if (!inv_nxt) begin
        st = fud_pkg::ST_NO_EQUALS;
      end else if (!kne_nxt) begin
        st = fud_pkg::ST_EMPTY_KEY;
      end else begin
        st = fud_pkg::ST_ACCEPTED;
      end
      g = fud_pkg::grp_push(g, fud_pkg::mk_res(8'd0, fud_pkg::KIND_BODY_END, st, !bx_nxt));
      hc_nxt  = 2'd0;
      hch_nxt = 8'd0;
      inv_nxt = 1'b0;
      kne_nxt = 1'b0;
      acc_nxt = '0;
      bx_nxt  = 1'b0;
    end

    if (g.cnt != 3'd0) begin
      last_idx = g.cnt[1:0] - 2'd1;
      g.ent[last_idx].fin = 1'b1;
    end
  end

  assign grp = g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r  <= 2'd0;
      hch_r <= 8'd0;
      inv_r <= 1'b0;
      kne_r <= 1'b0;
      acc_r <= '0;
      bx_r  <= 1'b0;
    end else if (adv) begin
      hc_r  <= hc_nxt;
      hch_r <= hch_nxt;
      inv_r <= inv_nxt;
      kne_r <= kne_nxt;
      acc_r <= acc_nxt;
      bx_r  <= bx_nxt;
    end
  end

endmodule

FILE: src/fud_outq.sv
`timescale 1ns / 1ps

module fud_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  fud_pkg::grp_t  grp_in,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_stall,
  output fud_pkg::res_t  head
);

  fud_pkg::res_t [fud_pkg::MAX_RES-1:0] ent_r, ent_nxt;
  logic [2:0]                           cnt_r, cnt_nxt;
  logic                                 pop;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign can_load  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && pop);
  assign head      = ent_r[0];

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = grp_in.ent;
      cnt_nxt = grp_in.cnt;
    end else if (pop) begin
      for (int i = 0; i < fud_pkg::MAX_RES - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      ent_nxt[fud_pkg::MAX_RES-1] = '0;
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/form_urlencoded_decoder.sv
`timescale 1ns / 1ps

// Streaming application/x-www-form-urlencoded body parser. Each input beat
// carries one raw body byte and a flag for the final byte of the body. The
// output channel delivers decoded key bytes, value bytes, a status beat at the
// end of every pair that an '&' closes before the pair budget runs out, and
// one body-end beat whose status covers the final pair; the last beat caused
// by an input byte has out_final_result set. A byte enters an input register,
// from which the decode logic works out all its results at once and loads
// them into a four-entry result buffer that drains one beat per cycle unless
// out_stall is set. The input is taken every cycle while out_stall is low and
// each byte yields at most one result; a byte that yields more (up to four,
// for example a broken escape closed by '&' at the end of the body) holds the
// input until its last result leaves, since the result buffer only takes a
// new group when its last beat leaves. A byte that yields no result (a held
// '%' or hex digit, or a non-final byte once over budget) does not hold the
// input. cfg_pair_limit is the most accepted pairs per body (zero means no
// limit, 64 after reset); write it only while the block is idle.

module form_urlencoded_decoder #(
  parameter int PAIR_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_pair_limit,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_body_byte,
  input  logic        in_body_last,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_pair_status,
  output logic        out_body_ok,
  output logic        out_final_result
);

  // Pair budget register.
  logic [15:0] pair_limit_r;

  // Input register: holds one byte until the result buffer can take its group.
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  logic          accept;
  logic          advance;
  logic          can_load;
  fud_pkg::grp_t grp;
  fud_pkg::res_t head;

  assign advance  = s1_valid_r && can_load;
  assign in_stall = s1_valid_r && !can_load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pair_limit_r <= 16'd64;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_wr_en) begin
        pair_limit_r <= cfg_pair_limit;
      end
    end
  end

  // The payload only moves when a new beat is accepted, so it holds while the
  // register is stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_body_byte;
      s1_last_r <= in_body_last;
    end
  end

  // Parser state and the decode of one byte into its result group.
  fud_step #(
    .CNT_W (PAIR_COUNT_BITS)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (advance),
    .byte_i     (s1_byte_r),
    .last_i     (s1_last_r),
    .pair_limit (pair_limit_r),
    .grp        (grp)
  );

  // Result buffer: takes whole groups; one beat out per cycle unless stalled.
  fud_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .grp_in    (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_data_byte    = head.data;
  assign out_kind         = head.kind;
  assign out_pair_status  = head.status;
  assign out_body_ok      = head.ok;
  assign out_final_result = head.fin;

endmodule

FILE: src/fud_checker.sv
`timescale 1ns / 1ps

module fud_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic [1:0] out_kind,
  input logic [1:0] out_pair_status,
  input logic       out_body_ok,
  input logic       out_final_result
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) &&
      $stable(out_kind) && $stable(out_pair_status) && $stable(out_body_ok) &&
      $stable(out_final_result))
    else $error("result beat changed while stalled");

  // The input only backs up behind results that are waiting to leave.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Data beats carry no status.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == fud_pkg::KIND_KEY || out_kind == fud_pkg::KIND_VALUE)
      |-> out_pair_status == fud_pkg::ST_ACCEPTED && !out_body_ok)
    else $error("data beat with status bits set");

  // The body end is always the last result of its byte.
  a_body_end_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == fud_pkg::KIND_BODY_END |-> out_final_result)
    else $error("body end not marked final");

  // body_ok only on a body end that did not run over budget.
  a_body_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_body_ok |->
      out_kind == fud_pkg::KIND_BODY_END && out_pair_status != fud_pkg::ST_OVER_BUDGET)
    else $error("body_ok set on a wrong beat");

endmodule

bind form_urlencoded_decoder fud_checker u_fud_checker (.*);
